// ===== hdl/rbp_pkg.sv =====
// ---------------------------------------------------------------------------
// rbp_pkg: shared types and constants for the radar blip projector
// Register indexes, reset values, field widths and the datapath word type.
// ---------------------------------------------------------------------------
package rbp_pkg;

  localparam int unsigned DefCoordBits   = 16;
  localparam int unsigned DefCordicStages = 16;

  localparam int unsigned FieldW   = 16;
  localparam int unsigned ScaledW  = 25;   // rel * scale / 256, signed
  localparam int unsigned CordW    = 28;   // CORDIC word, headroom for gain
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned NumRegs  = 6;

  localparam logic [16:0] InvGainQ16 = 17'd39797;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_VIEW_COS  = 3'd3,
    REG_VIEW_SIN  = 3'd4,
    REG_SCALE     = 3'd5
  } reg_idx_e;

  localparam logic [15:0] RstOriginX = 16'd0;
  localparam logic [15:0] RstOriginY = 16'd0;
  localparam logic [15:0] RstRadius  = 16'd0;
  localparam logic [15:0] RstViewCos = 16'd16384;
  localparam logic [15:0] RstViewSin = 16'd0;
  localparam logic [15:0] RstScale   = 16'd6554;

  // configuration snapshot handed to the datapath
  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic        [15:0] show_radius;
    logic signed [15:0] view_cos;
    logic signed [15:0] view_sin;
    logic        [15:0] display_scale;
  } cfg_t;

  // one CORDIC cell's payload
  typedef struct packed {
    logic               vld;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] u;
    logic signed [CordW-1:0] v;
    logic               flip;
    logic               clamped;
    logic signed [ScaledW-1:0] sx;
    logic signed [ScaledW-1:0] sy;
    logic               last;
  } cell_t;

endpackage

// ===== hdl/rbp_if.sv =====
// ---------------------------------------------------------------------------
// rbp_in_if / rbp_out_if: valid/ready channels of the blip projector
// Input carries a target offset, output a marker position.
// ---------------------------------------------------------------------------
interface rbp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rel_x;
  logic signed [15:0] rel_y;
  logic               last_blip;
  modport source (output valid, rel_x, rel_y, last_blip, input ready);
  modport sink   (input valid, rel_x, rel_y, last_blip, output ready);
endinterface

interface rbp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic               was_clamped;
  logic               last_out;
  modport source (output valid, screen_x, screen_y, was_clamped, last_out, input ready);
  modport sink   (input valid, screen_x, screen_y, was_clamped, last_out, output ready);
endinterface

// ===== hdl/rbp_cell.sv =====
// ---------------------------------------------------------------------------
// rbp_cell: one CORDIC micro-rotation
// Vectors (x,y) toward the axis and turns (u,v) the opposite way by the same angle.
// ---------------------------------------------------------------------------
module rbp_cell
  import rbp_pkg::*;
#(
  parameter int unsigned Shift = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cell_t cell_i,
  output cell_t cell_o
);
  cell_t cell_d, cell_q;
  logic  dir;

  always_comb begin
    cell_d = cell_i;
    dir    = cell_i.y > 0;
    if (dir) begin
      cell_d.x = cell_i.x + (cell_i.y >>> Shift);
      cell_d.y = cell_i.y - (cell_i.x >>> Shift);
      cell_d.u = cell_i.u - (cell_i.v >>> Shift);
      cell_d.v = cell_i.v + (cell_i.u >>> Shift);
    end else begin
      cell_d.x = cell_i.x - (cell_i.y >>> Shift);
      cell_d.y = cell_i.y + (cell_i.x >>> Shift);
      cell_d.u = cell_i.u + (cell_i.v >>> Shift);
      cell_d.v = cell_i.v - (cell_i.u >>> Shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.vld <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule

// ===== hdl/rbp_cfg.sv =====
// ---------------------------------------------------------------------------
// rbp_cfg: APB register file
// Six 16-bit registers at byte offsets 4*i.
// ---------------------------------------------------------------------------
module rbp_cfg
  import rbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW+1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);
  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[PaddrW+1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= RstOriginX;
      cfg_q.origin_y      <= RstOriginY;
      cfg_q.show_radius   <= RstRadius;
      cfg_q.view_cos      <= RstViewCos;
      cfg_q.view_sin      <= RstViewSin;
      cfg_q.display_scale <= RstScale;
    end else if (wr) begin
      case (idx)
        REG_ORIGIN_X: cfg_q.origin_x      <= pwdata[15:0];
        REG_ORIGIN_Y: cfg_q.origin_y      <= pwdata[15:0];
        REG_RADIUS:   cfg_q.show_radius   <= pwdata[15:0];
        REG_VIEW_COS: cfg_q.view_cos      <= pwdata[15:0];
        REG_VIEW_SIN: cfg_q.view_sin      <= pwdata[15:0];
        REG_SCALE:    cfg_q.display_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X: prdata = {16'd0, cfg_q.origin_x};
      REG_ORIGIN_Y: prdata = {16'd0, cfg_q.origin_y};
      REG_RADIUS:   prdata = {16'd0, cfg_q.show_radius};
      REG_VIEW_COS: prdata = {16'd0, cfg_q.view_cos};
      REG_VIEW_SIN: prdata = {16'd0, cfg_q.view_sin};
      REG_SCALE:    prdata = {16'd0, cfg_q.display_scale};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

// ===== hdl/radar_blip_projector_top.sv =====
// ---------------------------------------------------------------------------
// radar_blip_projector_top: radar marker placement pipeline
// Scale, clamp to disc via CORDIC cell chain, rotate, offset, saturate.
// ---------------------------------------------------------------------------
// channel  | dir | handshake     | word
// in_if    | in  | valid/ready   | rel_x, rel_y, last_blip
// out_if   | out | valid/ready   | screen_x, screen_y, was_clamped, last_out
// apb      | in  | psel/penable  | 6 x 16-bit registers at 4*i
//
// One word per cycle sustained while out_if takes every word; the pipe is the
// chain of CORDIC cells plus scale, square, clamp-test, rotate, round stages.
// The whole pipe advances only when the output register is empty or taken,
// so a stall on out_if freezes every stage and drops in_if.ready.
// Reset (async, active low) clears all valid bits and loads register defaults.
module radar_blip_projector_top
  import rbp_pkg::*;
#(
  parameter int unsigned COORD_BITS    = DefCoordBits,
  parameter int unsigned CORDIC_STAGES = DefCordicStages
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rbp_in_if.sink            in_if,
  rbp_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW+1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam int unsigned ProdW = 48;
  localparam int unsigned SatW  = 33;

  cfg_t cfg;
  logic adv;

  rbp_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // output register is the skid: pipe moves whenever it can hand off
  logic o_vld_q;
  assign adv         = !o_vld_q || out_if.ready;
  assign in_if.ready = adv;

  // stage 1: scale
  logic s1_vld_q, s1_last_q;
  logic signed [ScaledW-1:0] s1_sx_q, s1_sy_q;
  logic signed [33:0] px_sc, py_sc;
  assign px_sc = in_if.rel_x * $signed({1'b0, cfg.display_scale});
  assign py_sc = in_if.rel_y * $signed({1'b0, cfg.display_scale});

  // stage 2: squares
  logic s2_vld_q, s2_last_q;
  logic signed [ScaledW-1:0] s2_sx_q, s2_sy_q;
  logic [47:0] s2_xx_q, s2_yy_q, r2_q;
  logic [23:0] r8;
  assign r8 = {cfg.show_radius, 8'd0};

  // stage 3: compare, CORDIC setup
  cell_t c0_q;
  logic [48:0] len2;
  logic        s3_clamp;
  logic        s3_flip;
  logic [40:0] u0;
  assign len2     = {1'b0, s2_xx_q} + {1'b0, s2_yy_q};
  assign s3_clamp = len2 > {1'b0, r2_q};
  assign s3_flip  = s2_sx_q < 0;
  assign u0       = r8 * InvGainQ16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      c0_q.vld <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_if.valid;
      s1_last_q <= in_if.last_blip;
      s1_sx_q   <= ScaledW'(px_sc >>> 8);
      s1_sy_q   <= ScaledW'(py_sc >>> 8);
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
      s2_sx_q   <= s1_sx_q;
      s2_sy_q   <= s1_sy_q;
      s2_xx_q   <= 48'(s1_sx_q * s1_sx_q);
      s2_yy_q   <= 48'(s1_sy_q * s1_sy_q);
      r2_q      <= r8 * r8;
      c0_q.vld     <= s2_vld_q;
      c0_q.last    <= s2_last_q;
      c0_q.clamped <= s3_clamp;
      c0_q.flip    <= s3_flip;
      c0_q.sx      <= s2_sx_q;
      c0_q.sy      <= s2_sy_q;
      c0_q.x       <= s3_flip ? -CordW'(s2_sx_q) : CordW'(s2_sx_q);
      c0_q.y       <= s3_flip ? -CordW'(s2_sy_q) : CordW'(s2_sy_q);
      c0_q.u       <= CordW'(u0[40:16]);
      c0_q.v       <= '0;
    end
  end

  // chain of CORDIC cells, one shift each
  cell_t chain [CORDIC_STAGES+1];
  assign chain[0] = c0_q;
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rbp_cell #(.Shift(g)) u_cell (
      .clk_i, .rst_ni, .en_i(adv), .cell_i(chain[g]), .cell_o(chain[g+1])
    );
  end

  // stage R1: pick vector, rotate products
  cell_t ce;
  logic signed [ScaledW-1:0] cx, cy;
  assign ce = chain[CORDIC_STAGES];
  always_comb begin
    if (ce.clamped) begin
      cx = ce.flip ? -ScaledW'(ce.u) : ScaledW'(ce.u);
      cy = ce.flip ? -ScaledW'(ce.v) : ScaledW'(ce.v);
    end else begin
      cx = ce.sx;
      cy = ce.sy;
    end
  end

  logic r1_vld_q, r1_last_q, r1_clamp_q;
  logic signed [40:0] r1_xc_q, r1_ys_q, r1_xs_q, r1_yc_q;
  // stage R2: sum, round, offset, saturate
  logic signed [ProdW-1:0] pxr, pyr;
  logic signed [SatW-1:0]  ox, oy;
  logic signed [SatW-1:0]  lim_hi, lim_lo;
  assign pxr = ProdW'(r1_xc_q) - ProdW'(r1_ys_q) + (ProdW'(1) <<< 21);
  assign pyr = ProdW'(r1_xs_q) + ProdW'(r1_yc_q) + (ProdW'(1) <<< 21);
  assign ox  = SatW'(cfg.origin_x) + SatW'(pxr >>> 22);
  assign oy  = SatW'(cfg.origin_y) + SatW'(pyr >>> 22);
  assign lim_hi = (SatW'(1) <<< (COORD_BITS - 1)) - SatW'(1);
  assign lim_lo = -(SatW'(1) <<< (COORD_BITS - 1));

  logic signed [15:0] sat_x, sat_y;
  assign sat_x = (ox > lim_hi) ? lim_hi[15:0] : (ox < lim_lo) ? lim_lo[15:0] : ox[15:0];
  assign sat_y = (oy > lim_hi) ? lim_hi[15:0] : (oy < lim_lo) ? lim_lo[15:0] : oy[15:0];

  logic signed [15:0] o_x_q, o_y_q;
  logic o_clamp_q, o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (adv) begin
      r1_vld_q   <= ce.vld;
      r1_last_q  <= ce.last;
      r1_clamp_q <= ce.clamped;
      r1_xc_q    <= cx * cfg.view_cos;
      r1_ys_q    <= cy * cfg.view_sin;
      r1_xs_q    <= cx * cfg.view_sin;
      r1_yc_q    <= cy * cfg.view_cos;
      o_vld_q    <= r1_vld_q;
      o_last_q   <= r1_last_q;
      o_clamp_q  <= r1_clamp_q;
      o_x_q      <= sat_x;
      o_y_q      <= sat_y;
    end
  end

  assign out_if.valid       = o_vld_q;
  assign out_if.screen_x    = o_x_q;
  assign out_if.screen_y    = o_y_q;
  assign out_if.was_clamped = o_clamp_q;
  assign out_if.last_out    = o_last_q;
endmodule

// ===== hdl/rbp_checker.sv =====
// ---------------------------------------------------------------------------
// rbp_checker: port-level checks for the blip projector
// Output handshake, flow control and APB pready properties.
// ---------------------------------------------------------------------------
module rbp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic was_clamped,
  input logic pready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("output word dropped");
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(was_clamped)) else $error("output word changed");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("pipe stalled while empty");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");
endmodule

bind radar_blip_projector_top rbp_checker u_rbp_checker (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .was_clamped(out_if.was_clamped), .pready
);

// ===== tb/rbp_blip_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rbp_blip_checker: marker position predictor and scoreboard
// Mirrors the register writes seen on the APB port, predicts the marker for
// every accepted target word and compares each output word in order.
// ---------------------------------------------------------------------------
module rbp_blip_checker
  import rbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  rbp_in_if                 in_mon,
  rbp_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [PaddrW+1:0] paddr,
  input  logic [31:0]       pwdata,
  output int unsigned       fail_cnt_o,
  output int unsigned       pending_o,
  output int unsigned       clamp_cnt_o,
  output logic              accept_o
);

  localparam int unsigned Stages = DefCordicStages;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               was_clamped;
    logic               last_out;
  } marker_t;

  logic signed [15:0] org_x, org_y, trig_cos, trig_sin;
  logic        [15:0] disc_rad, scale_q;
  marker_t            marker_q[$];
  int unsigned        fail_cnt = 0;
  int unsigned        clamp_cnt = 0;

  function automatic longint sat_coord(longint v);
    longint lim;
    lim = longint'(1) <<< (DefCoordBits - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic marker_t project_blip(logic signed [15:0] rx, logic signed [15:0] ry,
                                           logic lb);
    longint  sx, sy, len2, r8, cx, cy, x, y, u, v, xs, ys, us, vs, px, py;
    bit      dir[Stages];
    bit      flip, clamped;
    marker_t m;
    sx      = (longint'(rx) * longint'(scale_q)) >>> 8;
    sy      = (longint'(ry) * longint'(scale_q)) >>> 8;
    len2    = sx * sx + sy * sy;
    r8      = longint'(disc_rad) << 8;
    clamped = len2 > r8 * r8;
    cx = sx;
    cy = sy;
    if (clamped) begin
      flip = sx < 0;
      x = flip ? -sx : sx;
      y = flip ? -sy : sy;
      // vectoring: remember which way each micro-rotation went
      for (int i = 0; i < Stages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        dir[i] = y > 0;
        if (dir[i]) begin
          x = x + ys; y = y - xs;
        end else begin
          x = x - ys; y = y + xs;
        end
      end
      // replay on (radius, 0), pre-scaled by the inverse gain
      u = (r8 * longint'(InvGainQ16)) >> 16;
      v = 0;
      for (int i = 0; i < Stages; i++) begin
        us = u >>> i;
        vs = v >>> i;
        if (dir[i]) begin
          u = u - vs; v = v + us;
        end else begin
          u = u + vs; v = v - us;
        end
      end
      cx = flip ? -u : u;
      cy = flip ? -v : v;
    end
    px = cx * longint'(trig_cos) - cy * longint'(trig_sin);
    py = cx * longint'(trig_sin) + cy * longint'(trig_cos);
    m.screen_x    = 16'(sat_coord(longint'(org_x) + ((px + (longint'(1) << 21)) >>> 22)));
    m.screen_y    = 16'(sat_coord(longint'(org_y) + ((py + (longint'(1) << 21)) >>> 22)));
    m.was_clamped = clamped;
    m.last_out    = lb;
    return m;
  endfunction

  // register mirror; the bench must write it only while the pipe is empty, not enforced here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x    <= RstOriginX;
      org_y    <= RstOriginY;
      disc_rad <= RstRadius;
      trig_cos <= RstViewCos;
      trig_sin <= RstViewSin;
      scale_q  <= RstScale;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[PaddrW+1:2])
        REG_ORIGIN_X: org_x    <= pwdata[15:0];
        REG_ORIGIN_Y: org_y    <= pwdata[15:0];
        REG_RADIUS:   disc_rad <= pwdata[15:0];
        REG_VIEW_COS: trig_cos <= pwdata[15:0];
        REG_VIEW_SIN: trig_sin <= pwdata[15:0];
        REG_SCALE:    scale_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    marker_t want, got;
    if (rst_ni && in_mon.valid && in_mon.ready)
      marker_q.push_back(project_blip(in_mon.rel_x, in_mon.rel_y, in_mon.last_blip));
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      got = {out_mon.screen_x, out_mon.screen_y, out_mon.was_clamped, out_mon.last_out};
      if (got.was_clamped) clamp_cnt++;
      if (marker_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected marker x=%0d y=%0d c=%0b l=%0b", $time,
                 got.screen_x, got.screen_y, got.was_clamped, got.last_out);
      end else begin
        want = marker_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          $display("%0t: marker mismatch exp x=%0d y=%0d c=%0b l=%0b act x=%0d y=%0d c=%0b l=%0b",
                   $time, want.screen_x, want.screen_y, want.was_clamped, want.last_out,
                   got.screen_x, got.screen_y, got.was_clamped, got.last_out);
        end
      end
    end
  end

  assign fail_cnt_o  = fail_cnt;
  assign clamp_cnt_o = clamp_cnt;
  assign pending_o   = marker_q.size();
  assign accept_o    = (in_mon.valid && in_mon.ready) || (out_mon.valid && out_mon.ready);

endmodule

// ===== tb/tb_radar_blip_projector_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_radar_blip_projector_top: stimulus and verdict for the blip projector
// Directed extremes at reset settings and on a set disc, then random target
// words over a series of register settings, random stalls on both channels.
// ---------------------------------------------------------------------------
module tb_radar_blip_projector_top;
  import rbp_pkg::*;

  localparam int unsigned NumPhases    = 8;
  localparam int unsigned WordsPerPhase = 130;
  localparam int unsigned SettleCycles = 40;    // idle pause after a drain, longer than the pipe latency
  localparam int unsigned HoldCycles   = 300;   // long receiver stall
  localparam int unsigned IdleLimit    = 5000;  // watchdog, cycles w/o accept
  localparam logic [PaddrW+1:0] UnmappedAddr = 5'd24;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW+1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned fail_cnt, pending, clamp_cnt, idle_cnt, sent_cnt;
  logic        accept;
  bit          calm = 1'b0;      // no idling on either side
  bit          hold_req = 1'b0;  // ask the receiver for a long stall

  rbp_in_if  in_if();
  rbp_out_if out_if();

  always #5 clk_i = ~clk_i;

  radar_blip_projector_top u_top (
    .clk_i, .rst_ni, .in_if, .out_if,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rbp_blip_checker u_chk (
    .clk_i, .rst_ni, .in_mon(in_if), .out_mon(out_if),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .clamp_cnt_o(clamp_cnt),
    .accept_o(accept)
  );

  // watchdog: a hung pipe ends the run
  always @(posedge clk_i) begin
    if (accept || !rst_ni) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IdleLimit) begin
      $display("watchdog: nothing accepted for %0d cycles", IdleLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random ready bursts, one long hold on request, steady when calm
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(0, 9) < 7);
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  // two-phase APB write
  task automatic apb_write(logic [PaddrW+1:0] addr, logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [PaddrW+1:0] reg_addr(reg_idx_e idx);
    return {idx, 2'b00};
  endfunction

  // offer one target word, optionally after an idle gap, until taken
  task automatic send_blip(logic signed [15:0] rx, logic signed [15:0] ry, logic lb);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.rel_x     <= rx;
    in_if.rel_y     <= ry;
    in_if.last_blip <= lb;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // stop offering, let every marker come out, then let the pipe settle
  task automatic drain;
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // full-range word with random magnitude so both clamp outcomes occur
  function automatic logic signed [15:0] rand_offset;
    logic signed [15:0] v;
    v = 16'($urandom);
    return v >>> $urandom_range(0, 15);
  endfunction

  task automatic load_setting(int unsigned ph);
    logic [15:0] ox, oy, rad, sc, c, s;
    real         ang;
    ang = $urandom_range(0, 6283) / 1000.0;
    ox  = 16'($urandom);
    oy  = 16'($urandom);
    rad = 16'($urandom_range(0, 4000));
    sc  = 16'($urandom);
    c   = 16'($rtoi($cos(ang) * 16384.0));
    s   = 16'($rtoi($sin(ang) * 16384.0));
    case (ph)
      0: begin  // top of origin, radius and scale ranges
        ox = 16'h7fff; oy = 16'h7fff; rad = 16'hffff; sc = 16'hffff;
        c = 16'd16384; s = 16'd16384;
      end
      1: begin  // bottom of every range, trig words at -2.0 in Q1.14, outside the unit range
        ox = 16'h8000; oy = 16'h8000; rad = 16'h0000; sc = 16'h0000;
        c = 16'h8000; s = 16'h8000;
      end
      2: begin  // heading turned half way round
        ox = 16'd0; oy = 16'd0; rad = 16'd2000; sc = 16'd6554;
        c = -16'sd16384; s = 16'd0;
      end
      3: begin rad = 16'd0; c = 16'd0; s = -16'sd16384; end
      default: ;
    endcase
    apb_write(reg_addr(REG_ORIGIN_X), ox);
    apb_write(reg_addr(REG_ORIGIN_Y), oy);
    apb_write(reg_addr(REG_RADIUS), rad);
    apb_write(reg_addr(REG_VIEW_COS), c);
    apb_write(reg_addr(REG_VIEW_SIN), s);
    apb_write(reg_addr(REG_SCALE), sc);
    // writes to the hole above the map must not land anywhere
    if (ph % 2 == 0) apb_write(UnmappedAddr + 5'(4 * (ph % 4 / 2)), 16'($urandom));
  endtask

  initial begin
    sent_cnt        = 0;
    in_if.valid     = 1'b0;
    in_if.rel_x     = '0;
    in_if.rel_y     = '0;
    in_if.last_blip = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words under reset settings: zero radius clamps everything nonzero
    send_blip(16'sd0, 16'sd0, 1'b0);
    send_blip(16'sd1, 16'sd0, 1'b0);
    send_blip(16'sh7fff, 16'sh7fff, 1'b0);
    send_blip(16'sh8000, 16'sh8000, 1'b1);
    drain();

    // directed words with a real disc: inside, outside, each quadrant
    apb_write(reg_addr(REG_RADIUS), 16'd1000);
    apb_write(reg_addr(REG_ORIGIN_X), 16'd800);
    apb_write(reg_addr(REG_ORIGIN_Y), -16'sd800);
    send_blip(16'sd0, 16'sd0, 1'b0);
    send_blip(16'sd100, -16'sd100, 1'b0);
    send_blip(-16'sd5, 16'sd3, 1'b0);
    send_blip(16'sh7fff, 16'sd0, 1'b0);
    send_blip(16'sh8000, 16'sd0, 1'b0);
    send_blip(16'sd0, 16'sh7fff, 1'b0);
    send_blip(16'sd0, 16'sh8000, 1'b0);
    send_blip(16'sh8000, 16'sh7fff, 1'b0);
    send_blip(16'sh7fff, 16'sh8000, 1'b0);
    send_blip(-16'sd1, -16'sd1, 1'b0);
    send_blip(16'sd10000, 16'sd10000, 1'b1);
    drain();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      load_setting(ph);
      calm = (ph == NumPhases - 1);
      if (ph == 4) hold_req = 1'b1;
      for (int unsigned n = 0; n < WordsPerPhase; n++)
        send_blip(rand_offset(), rand_offset(), ($urandom_range(0, 7) == 0));
      drain();
    end

    $display("run covered %0d target words over %0d register settings, %0d clamped",
             sent_cnt, NumPhases + 2, clamp_cnt);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
